// ===== hw/rtl/nbdpa_pkg.sv =====
// ----------------------------------------------------------------------------
// nbdpa_pkg
// shared types, widths and helper functions for the pair accumulator
// ----------------------------------------------------------------------------
package nbdpa_pkg;

    localparam int SUM_W  = 64;
    localparam int WIDE_W = 128;
    localparam int WGT_W  = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_GO,
        S_SQ_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_POT_GO,
        S_POT_WAIT,
        S_AX_MUL_GO,
        S_AX_MUL_WAIT,
        S_AX_DIV_GO,
        S_AX_DIV_WAIT,
        S_EMIT
    } state_t;

    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    // wide magnitude plus sign to a clamped signed 64-bit pattern
    function automatic logic [SUM_W-1:0] signed_term(input logic [WIDE_W-1:0] mag,
                                                     input logic neg);
        logic [SUM_W-1:0] m;
        logic [SUM_W-1:0] r;
        m = (mag[WIDE_W-1:SUM_W] != '0 || mag[SUM_W-1:0] > SUM_MIN) ? SUM_MIN
                                                                    : mag[SUM_W-1:0];
        if (neg)
        begin
            r = '0 - m;
        end
        else
        begin
            r = (m >= SUM_MIN) ? SUM_MAX : m;
        end
        return r;
    endfunction

    // signed 64-bit add that clamps on overflow
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] r;
        r = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && a[SUM_W-1] != r[SUM_W-1])
        begin
            r = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/nbdpa_pair_if.sv =====
// ----------------------------------------------------------------------------
// nbdpa_pair_if
// input channel: target point, one source point and its weight
// ----------------------------------------------------------------------------
interface nbdpa_pair_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;
    logic signed [COORD_WIDTH-1:0] source_x;
    logic signed [COORD_WIDTH-1:0] source_y;
    logic signed [COORD_WIDTH-1:0] source_z;
    logic [nbdpa_pkg::WGT_W-1:0]   source_weight;
    logic                          last_source;

    modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                    source_z, source_weight, last_source, input ready);
    modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, source_weight, last_source, output ready);
endinterface

// ===== hw/rtl/nbdpa_sum_if.sv =====
// ----------------------------------------------------------------------------
// nbdpa_sum_if
// result channel: potential and acceleration sums
// ----------------------------------------------------------------------------
interface nbdpa_sum_if;
    logic                               valid;
    logic                               ready;
    logic signed [nbdpa_pkg::SUM_W-1:0] potential;
    logic signed [nbdpa_pkg::SUM_W-1:0] accel_x;
    logic signed [nbdpa_pkg::SUM_W-1:0] accel_y;
    logic signed [nbdpa_pkg::SUM_W-1:0] accel_z;

    modport source (output valid, potential, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, potential, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== hw/rtl/nbody_direct_pair_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// nbody_direct_pair_accumulator_top
// direct particle pair interaction, accumulated per target point
// ----------------------------------------------------------------------------
// Each input beat carries a target point, one source point and its weight.
// The block forms d = source - target and r = sqrt(|d|^2), then adds w/r to
// the potential sum and d*w/r^3 to the three acceleration sums (signed Q32.32,
// saturating). A pair with r = 0 adds nothing. On a beat with last_source set
// the beat is accumulated first, then the four sums go out as one result beat
// and are cleared. One beat is worked on at a time and the input is not ready
// meanwhile; the result sits in an output register, so the next beat can be
// taken while a result waits. The work for a beat is ten 128-step divisions
// on the shared divider (one for the potential, three per axis for w/r^3),
// three squarings and three weight products on the shift-add multiplier,
// which stops once the remaining multiplier bits are zero, and a 64-step
// square root. A coincident pair stops after the square root, as the
// squarings of zero finish at once.
// ----------------------------------------------------------------------------
module nbody_direct_pair_accumulator_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    nbdpa_pair_if.sink  pair,
    nbdpa_sum_if.source result
);
    localparam int DW = COORD_WIDTH + 1;

    nbdpa_pkg::state_t state_reg, state_next;

    // per-pair working registers
    logic signed [DW-1:0]                d_reg [0:2];
    logic signed [DW-1:0]                d_next [0:2];
    logic [nbdpa_pkg::WGT_W-1:0]         w_reg, w_next;
    logic                                last_reg, last_next;
    logic [nbdpa_pkg::WIDE_W-1:0]        r2_reg, r2_next;
    logic [63:0]                         s_reg, s_next;
    logic [nbdpa_pkg::WIDE_W-1:0]        x_reg, x_next;
    logic [1:0]                          axis_reg, axis_next;
    logic [1:0]                          round_reg, round_next;

    // running sums
    logic [nbdpa_pkg::SUM_W-1:0]         pot_reg, pot_next;
    logic [nbdpa_pkg::SUM_W-1:0]         acc_reg [0:2];
    logic [nbdpa_pkg::SUM_W-1:0]         acc_next [0:2];

    // result register
    logic                                out_valid_reg, out_valid_next;
    logic [nbdpa_pkg::SUM_W-1:0]         out_pot_reg, out_pot_next;
    logic [nbdpa_pkg::SUM_W-1:0]         out_acc_reg [0:2];
    logic [nbdpa_pkg::SUM_W-1:0]         out_acc_next [0:2];

    // shared unit handshakes
    logic                                mul_start, mul_done;
    logic [63:0]                         mul_a, mul_b;
    logic [nbdpa_pkg::WIDE_W-1:0]        mul_addend, mul_prod;
    logic                                sqrt_start, sqrt_done;
    logic [63:0]                         sqrt_root;
    logic                                div_start, div_done;
    logic [nbdpa_pkg::WIDE_W-1:0]        div_num, div_quo;

    // current axis: sign and magnitude of d
    logic signed [DW-1:0]                d_cur;
    logic                                d_neg;
    logic [DW-1:0]                       d_mag;
    logic [63:0]                         d_mag64;

    assign d_cur   = d_reg[axis_reg];
    assign d_neg   = d_cur[DW-1];
    assign d_mag   = d_neg ? DW'(-d_cur) : DW'(d_cur);
    assign d_mag64 = {{(64-DW){1'b0}}, d_mag};

    assign pair.ready = (state_reg == nbdpa_pkg::S_IDLE);

    nbdpa_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .addend (mul_addend),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    nbdpa_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (r2_reg << 30),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    nbdpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (s_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        d_next         = d_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        r2_next        = r2_reg;
        s_next         = s_reg;
        x_next         = x_reg;
        axis_next      = axis_reg;
        round_next     = round_reg;
        pot_next       = pot_reg;
        acc_next       = acc_reg;
        out_pot_next   = out_pot_reg;
        out_acc_next   = out_acc_reg;
        out_valid_next = out_valid_reg;
        mul_start      = 1'b0;
        mul_a          = d_mag64;
        mul_b          = d_mag64;
        mul_addend     = r2_reg;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        div_num        = x_reg << 31;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nbdpa_pkg::S_IDLE:
            begin
                if (pair.valid)
                begin
                    // sign-extend by one bit so the difference cannot wrap
                    d_next[0]  = $signed({pair.source_x[COORD_WIDTH-1], pair.source_x})
                               - $signed({pair.target_x[COORD_WIDTH-1], pair.target_x});
                    d_next[1]  = $signed({pair.source_y[COORD_WIDTH-1], pair.source_y})
                               - $signed({pair.target_y[COORD_WIDTH-1], pair.target_y});
                    d_next[2]  = $signed({pair.source_z[COORD_WIDTH-1], pair.source_z})
                               - $signed({pair.target_z[COORD_WIDTH-1], pair.target_z});
                    w_next     = pair.source_weight;
                    last_next  = pair.last_source;
                    r2_next    = '0;
                    axis_next  = 2'd0;
                    state_next = nbdpa_pkg::S_SQ_GO;
                end
            end
            nbdpa_pkg::S_SQ_GO:
            begin
                // r2 += |d|^2 for the current axis
                mul_start  = 1'b1;
                state_next = nbdpa_pkg::S_SQ_WAIT;
            end
            nbdpa_pkg::S_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    r2_next = mul_prod;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = nbdpa_pkg::S_SQRT_GO;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = nbdpa_pkg::S_SQ_GO;
                    end
                end
            end
            nbdpa_pkg::S_SQRT_GO:
            begin
                // root of r2 in Q.32 scaled by 2^30 gives r in Q.31
                sqrt_start = 1'b1;
                state_next = nbdpa_pkg::S_SQRT_WAIT;
            end
            nbdpa_pkg::S_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    s_next = sqrt_root;
                    // coincident points add nothing
                    state_next = (sqrt_root == '0) ? nbdpa_pkg::S_EMIT
                                                   : nbdpa_pkg::S_POT_GO;
                end
            end
            nbdpa_pkg::S_POT_GO:
            begin
                div_start  = 1'b1;
                div_num    = {49'b0, w_reg, 47'b0};
                state_next = nbdpa_pkg::S_POT_WAIT;
            end
            nbdpa_pkg::S_POT_WAIT:
            begin
                if (div_done)
                begin
                    pot_next   = nbdpa_pkg::sat_add(pot_reg,
                                                    nbdpa_pkg::signed_term(div_quo, 1'b0));
                    state_next = nbdpa_pkg::S_AX_MUL_GO;
                end
            end
            nbdpa_pkg::S_AX_MUL_GO:
            begin
                // x = |d| * w, weight bits drive the iteration
                mul_start  = 1'b1;
                mul_b      = {32'b0, w_reg};
                mul_addend = '0;
                state_next = nbdpa_pkg::S_AX_MUL_WAIT;
            end
            nbdpa_pkg::S_AX_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    x_next     = mul_prod;
                    round_next = 2'd0;
                    state_next = nbdpa_pkg::S_AX_DIV_GO;
                end
            end
            nbdpa_pkg::S_AX_DIV_GO:
            begin
                // x = (x << 31) / s, three times for 1/r^3
                div_start  = 1'b1;
                state_next = nbdpa_pkg::S_AX_DIV_WAIT;
            end
            nbdpa_pkg::S_AX_DIV_WAIT:
            begin
                if (div_done)
                begin
                    x_next = div_quo;
                    if (round_reg == 2'd2)
                    begin
                        acc_next[axis_reg] = nbdpa_pkg::sat_add(acc_reg[axis_reg],
                            nbdpa_pkg::signed_term(div_quo, d_neg));
                        if (axis_reg == 2'd2)
                        begin
                            state_next = nbdpa_pkg::S_EMIT;
                        end
                        else
                        begin
                            axis_next  = axis_reg + 2'd1;
                            state_next = nbdpa_pkg::S_AX_MUL_GO;
                        end
                    end
                    else
                    begin
                        round_next = round_reg + 2'd1;
                        state_next = nbdpa_pkg::S_AX_DIV_GO;
                    end
                end
            end
            nbdpa_pkg::S_EMIT:
            begin
                if (!last_reg)
                begin
                    state_next = nbdpa_pkg::S_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    // hand the sums to the result register and start over
                    out_valid_next = 1'b1;
                    out_pot_next   = pot_reg;
                    out_acc_next   = acc_reg;
                    pot_next       = '0;
                    acc_next[0]    = '0;
                    acc_next[1]    = '0;
                    acc_next[2]    = '0;
                    state_next     = nbdpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nbdpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nbdpa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            pot_reg       <= '0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            axis_reg      <= 2'd0;
            round_reg     <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pot_reg       <= pot_next;
            acc_reg       <= acc_next;
            axis_reg      <= axis_next;
            round_reg     <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        w_reg       <= w_next;
        last_reg    <= last_next;
        r2_reg      <= r2_next;
        s_reg       <= s_next;
        x_reg       <= x_next;
        out_pot_reg <= out_pot_next;
        out_acc_reg <= out_acc_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.potential = out_pot_reg;
    assign result.accel_x   = out_acc_reg[0];
    assign result.accel_y   = out_acc_reg[1];
    assign result.accel_z   = out_acc_reg[2];
endmodule

// ===== hw/rtl/nbdpa_mul.sv =====
// ----------------------------------------------------------------------------
// nbdpa_mul
// shift-add multiplier with addend, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module nbdpa_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [63:0]                   a,
    input  logic [63:0]                   b,
    input  logic [nbdpa_pkg::WIDE_W-1:0]  addend,
    output logic                          done,
    output logic [nbdpa_pkg::WIDE_W-1:0]  prod
);
    logic [nbdpa_pkg::WIDE_W-1:0] acc_reg, acc_next;
    logic [nbdpa_pkg::WIDE_W-1:0] a_reg, a_next;
    logic [63:0]                  b_reg, b_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = addend;
            a_next   = {64'b0, a};
            b_next   = b;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (b_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ===== hw/rtl/nbdpa_isqrt.sv =====
// ----------------------------------------------------------------------------
// nbdpa_isqrt
// digit-by-digit integer square root of a 128-bit value, two bits per cycle
// ----------------------------------------------------------------------------
module nbdpa_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nbdpa_pkg::WIDE_W-1:0]  radicand,
    output logic                          done,
    output logic [63:0]                   root
);
    logic [nbdpa_pkg::WIDE_W-1:0] n_reg, n_next;
    logic [65:0]                  rem_reg, rem_next;
    logic [63:0]                  root_reg, root_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [67:0]                  rem_sh;
    logic [67:0]                  trial;

    always_comb
    begin
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, n_reg[nbdpa_pkg::WIDE_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            n_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '1;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = 66'(rem_sh - trial);
                root_next = {root_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[65:0];
                root_next = {root_reg[62:0], 1'b0};
            end
            n_next   = n_reg << 2;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hw/rtl/nbdpa_div.sv =====
// ----------------------------------------------------------------------------
// nbdpa_div
// restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module nbdpa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nbdpa_pkg::WIDE_W-1:0]  dividend,
    input  logic [63:0]                   divisor,
    output logic                          done,
    output logic [nbdpa_pkg::WIDE_W-1:0]  quotient
);
    // dividend shifts out at the top while quotient bits enter at the bottom
    logic [nbdpa_pkg::WIDE_W-1:0] nq_reg, nq_next;
    logic [63:0]                  rem_reg, rem_next;
    logic [63:0]                  d_reg, d_next;
    logic [6:0]                   cnt_reg, cnt_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [64:0]                  rem_sh;
    logic                         qbit;

    always_comb
    begin
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, nq_reg[nbdpa_pkg::WIDE_W-1]};
        qbit      = (rem_sh >= {1'b0, d_reg});
        if (start)
        begin
            nq_next  = dividend;
            rem_next = '0;
            d_next   = divisor;
            cnt_next = '1;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = qbit ? 64'(rem_sh - {1'b0, d_reg}) : rem_sh[63:0];
            nq_next  = {nq_reg[nbdpa_pkg::WIDE_W-2:0], qbit};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = nq_reg;
endmodule

// ===== test/nbody_direct_pair_accumulator_top_test.sv =====
// ----------------------------------------------------------------------------
// nbody_direct_pair_accumulator_top_test
// pair accumulator check against an exact fixed-point predictor
// ----------------------------------------------------------------------------
// Drives target/source/weight beats through the pair channel. The result of
// each beat is worked out here in wide integers and then compared field by
// field with the result channel. Directed tests cover coincident points,
// coordinate and weight extremes, and term and sum saturation. Groups of
// random sources, one target per group, follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module nbody_direct_pair_accumulator_top_test;

    localparam int          CW          = 32;
    localparam int          RANDOM_BEATS = 1600;
    localparam longint      CYCLE_LIMIT = 12_000_000;
    localparam int          DRAIN_WAIT  = 2_000;
    localparam logic [63:0] TOP_BIT     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX     = 64'h7fff_ffff_ffff_ffff;

    typedef struct {
        logic signed [CW-1:0]           tx, ty, tz;
        logic signed [CW-1:0]           sx, sy, sz;
        logic [nbdpa_pkg::WGT_W-1:0]    weight;
        logic                           last;
    } pair_beat_t;

    typedef struct {
        logic [nbdpa_pkg::SUM_W-1:0] potential;
        logic [nbdpa_pkg::SUM_W-1:0] ax, ay, az;
    } field_sums_t;

    logic clk;
    logic rst_n;

    nbdpa_pair_if #(.COORD_WIDTH(CW)) pair();
    nbdpa_sum_if                      result();

    nbody_direct_pair_accumulator_top #(.COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .result (result)
    );

    // running sums of the predictor and the sums still owed by the block
    field_sums_t running;
    field_sums_t owed_sums[$];
    int          failures;
    longint      cycles = 0;
    bit          calm;      // both sides stop idling while set

    // ------------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: exact wide-integer arithmetic at the block's widths
    // ------------------------------------------------------------------------

    // floor(sqrt(n)), bit by bit
    function automatic logic [63:0] floor_root(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n)
                r = c;
        end
        return r;
    endfunction

    // wide magnitude and sign to a clamped signed 64-bit term
    function automatic logic [63:0] clamp_term(input logic [127:0] mag, input logic neg);
        logic [63:0] m;
        m = (mag[127:64] != '0 || mag[63:0] > TOP_BIT) ? TOP_BIT : mag[63:0];
        if (neg)
            return 64'd0 - m;
        return (m >= TOP_BIT) ? POS_MAX : m;
    endfunction

    function automatic logic [63:0] clamped_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? TOP_BIT : POS_MAX;
        return r;
    endfunction

    // d*w/r^3 for one axis, truncated toward zero
    function automatic logic [63:0] axis_pull(input logic signed [63:0] d,
                                              input logic [31:0] w, input logic [63:0] s);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] x;
        neg = d < 0;
        mag = neg ? -d : d;
        x   = {64'd0, mag} * {96'd0, w};
        for (int k = 0; k < 3; k++)
            x = (x << 31) / {64'd0, s};
        return clamp_term(x, neg);
    endfunction

    // fold one accepted beat into the running sums; emit on the last source
    task automatic accumulate_pair(input pair_beat_t p);
        logic signed [63:0] dx, dy, dz;
        logic [63:0]        mx, my, mz;
        logic [127:0]       r2;
        logic [63:0]        s;
        logic [127:0]       pot;
        dx = 64'(p.sx) - 64'(p.tx);
        dy = 64'(p.sy) - 64'(p.ty);
        dz = 64'(p.sz) - 64'(p.tz);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        mz = dz < 0 ? -dz : dz;
        r2 = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}
           + {64'd0, mz} * {64'd0, mz};
        s  = floor_root(r2 << 30);
        // coincident points add nothing
        if (s != 0)
        begin
            pot = ({96'd0, p.weight} << 47) / {64'd0, s};
            running.potential = clamped_add(running.potential, clamp_term(pot, 1'b0));
            running.ax = clamped_add(running.ax, axis_pull(dx, p.weight, s));
            running.ay = clamped_add(running.ay, axis_pull(dy, p.weight, s));
            running.az = clamped_add(running.az, axis_pull(dz, p.weight, s));
        end
        if (p.last)
        begin
            owed_sums.push_back(running);
            running = '{default: '0};
        end
    endtask

    // ------------------------------------------------------------------------
    // pair side: one beat per call, valid stays high across back-to-back beats
    // ------------------------------------------------------------------------
    task automatic send_pair(input pair_beat_t p);
        if (!calm)
        begin
            while ($urandom_range(99) < 33)
            begin
                pair.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pair.valid         <= 1'b1;
        pair.target_x      <= p.tx;
        pair.target_y      <= p.ty;
        pair.target_z      <= p.tz;
        pair.source_x      <= p.sx;
        pair.source_y      <= p.sy;
        pair.source_z      <= p.sz;
        pair.source_weight <= p.weight;
        pair.last_source   <= p.last;
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
        accumulate_pair(p);
    endtask

    function automatic pair_beat_t make_pair(input int tx, ty, tz, sx, sy, sz,
                                             input logic [31:0] w, input logic last);
        pair_beat_t p;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.weight = w;
        p.last = last;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the field-by-field compare
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= calm || ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        field_sums_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (owed_sums.size() == 0)
            begin
                $error("result beat with no sums owed");
                failures++;
            end
            else
            begin
                want = owed_sums.pop_front();
                if (result.potential !== want.potential)
                begin
                    $error("potential: expected %h, got %h", want.potential, result.potential);
                    failures++;
                end
                if (result.accel_x !== want.ax)
                begin
                    $error("accel_x: expected %h, got %h", want.ax, result.accel_x);
                    failures++;
                end
                if (result.accel_y !== want.ay)
                begin
                    $error("accel_y: expected %h, got %h", want.ay, result.accel_y);
                    failures++;
                end
                if (result.accel_z !== want.az)
                begin
                    $error("accel_z: expected %h, got %h", want.az, result.accel_z);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // r = 0: alone, then mixed into a group with a real pair
    task automatic test_coincident();
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'hffff_ffff, 1'b1));
        send_pair(make_pair(32'h0001_0000, -5, 7, 32'h0001_0000, -5, 7, 32'h0001_0000, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 1'b0));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, 32'h1234_5678, 1'b1));
    endtask

    // coordinate and weight extremes, every sign of d
    task automatic test_extremes();
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1));
        send_pair(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b1));
        send_pair(make_pair(0, 0, 0, 32'h0001_0000, 32'hffff_0000, 0, 32'h0000_0000, 1'b1));
        send_pair(make_pair(0, 0, 0, 32'hfffe_0000, 32'h0003_0000, 32'h0004_0000,
                            32'h0001_0000, 1'b0));
        send_pair(make_pair(32'h0010_0000, 0, 0, 0, 32'h0010_0000, 32'hfff0_0000,
                            32'h8000_0000, 1'b1));
    endtask

    // unit-lsb separations with heavy weights clamp the terms, then the sums
    task automatic test_saturation();
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 32'hffff_ffff, 1'b1));
        send_pair(make_pair(0, 0, 0, -1, 0, 0, 32'hffff_ffff, 1'b1));
        for (int i = 0; i < 4; i++)
            send_pair(make_pair(0, 0, 0, 0, 1, -1, 32'hffff_ffff, i == 3));
        for (int i = 0; i < 4; i++)
            send_pair(make_pair(5, 5, 5, 5, 5, 4, 32'h8000_0000, i == 3));
    endtask

    // groups of sources around one target, with some loose noise beats
    task automatic test_random_groups();
        pair_beat_t p;
        int         sent;
        int         group;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            calm = (sent >= 700 && sent < 850);
            if ($urandom_range(99) < 15)
            begin
                // noise: every field at random
                p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom_range(1));
                send_pair(p);
                sent++;
            end
            else
            begin
                group = $urandom_range(1, 6);
                p = make_pair($urandom, $urandom, $urandom, 0, 0, 0, 0, 1'b0);
                for (int i = 0; i < group; i++)
                begin
                    // offsets of random scale so r spans lsb to full range
                    p.sx = p.tx + ($signed($urandom) >>> $urandom_range(31));
                    p.sy = p.ty + ($signed($urandom) >>> $urandom_range(31));
                    p.sz = p.tz + ($signed($urandom) >>> $urandom_range(31));
                    p.weight = $urandom >> $urandom_range(31);
                    p.last = (i == group - 1);
                    send_pair(p);
                    sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        longint waited;
        failures = 0;
        calm     = 1'b0;
        running  = '{default: '0};
        rst_n    = 1'b0;
        pair.valid         <= 1'b0;
        pair.target_x      <= '0;
        pair.target_y      <= '0;
        pair.target_z      <= '0;
        pair.source_x      <= '0;
        pair.source_y      <= '0;
        pair.source_z      <= '0;
        pair.source_weight <= '0;
        pair.last_source   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coincident();
        test_extremes();
        test_saturation();
        test_random_groups();
        pair.valid <= 1'b0;

        // drain the owed sums, then give a stray beat time to show up
        waited = 0;
        while (owed_sums.size() != 0)
        begin
            @(posedge clk);
            waited++;
            if (waited > 100_000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
